// File: sv/bgt_pkg.sv
package bgt_pkg;

    // Depth of the battery moving-average ring.
    localparam int AVG_DEPTH = 8;

    // Field widths.
    localparam int ADC_W      = 12;
    localparam int TEMP_W     = 12;
    localparam int SET_W      = 11;
    localparam int OFS_W      = 8;
    localparam int MODE_W     = 2;
    localparam int BSUM_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Derived widths for the ring and its running sum.
    localparam int PTR_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W  = ADC_W + $clog2(AVG_DEPTH);
    localparam int SUMX_W = (SUM_W > BSUM_W) ? SUM_W : BSUM_W;
    localparam int LIM_W  = TEMP_W + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 3'd4;

    // Run mode codes.
    localparam logic [MODE_W-1:0] RUN_FORCED_OFF = 2'd0;
    localparam logic [MODE_W-1:0] RUN_AUTOMATIC  = 2'd1;
    localparam logic [MODE_W-1:0] RUN_FORCED_ON  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0]       RST_RUN_MODE  = RUN_AUTOMATIC;
    localparam logic signed [SET_W-1:0] RST_SETPOINT  = 11'sd400;
    localparam logic [OFS_W-1:0]        RST_ON_OFFSET = 8'd8;
    localparam logic [ADC_W-1:0]        RST_CUTOFF    = 12'd950;
    localparam logic [ADC_W-1:0]        RST_FLOOR     = 12'd10;

    typedef struct packed {
        logic [MODE_W-1:0]       run_mode;
        logic signed [SET_W-1:0] setpoint;
        logic [OFS_W-1:0]        on_offset;
        logic [ADC_W-1:0]        cutoff_counts;
        logic [ADC_W-1:0]        floor_counts;
    } cfg_t;

    typedef struct packed {
        logic [ADC_W-1:0]         adc_sample;
        logic signed [TEMP_W-1:0] temp_reading;
        logic                     temp_valid;
    } item_t;

endpackage

// File: sv/battery_guarded_thermostat_unit.sv
// Battery-guarded thermostat with an eight-sample battery moving average.
// An accepted item goes through the input stage register, then the result register.
// Throughput: one item per cycle while out_stall does not hold the result register.
// Reset (rst_n, asynchronous, active low) clears the ring, pointer, sum, held
// temperature and both valid flags, and loads the configuration reset values.
module battery_guarded_thermostat_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bgt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bgt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bgt_pkg::ADC_W-1:0]           adc_sample,
    input  logic signed [bgt_pkg::TEMP_W-1:0]   temp_reading,
    input  logic                                temp_valid,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                cooler_on,
    output logic                                cooler_allowed,
    output logic [bgt_pkg::BSUM_W-1:0]          battery_sum,
    output logic signed [bgt_pkg::TEMP_W-1:0]   held_temp
);

    bgt_pkg::cfg_t                      cfg;
    bgt_pkg::item_t                     in_item;
    bgt_pkg::item_t                     item;
    logic                               item_valid;
    logic                               out_free;
    logic                               advance;
    logic [bgt_pkg::SUM_W-1:0]          sum_next;
    logic [bgt_pkg::SUMX_W-1:0]         sum_x;
    logic signed [bgt_pkg::TEMP_W-1:0]  held_next;
    logic                               on_next;
    logic                               allowed_next;

    logic                               out_valid_reg;
    logic                               cooler_on_reg;
    logic                               cooler_allowed_reg;
    logic [bgt_pkg::BSUM_W-1:0]         battery_sum_reg;
    logic signed [bgt_pkg::TEMP_W-1:0]  held_temp_reg;

    assign in_item.adc_sample   = adc_sample;
    assign in_item.temp_reading = temp_reading;
    assign in_item.temp_valid   = temp_valid;

    // The result register frees up when empty or when its item is taken.
    assign out_free = ~out_valid_reg | ~out_stall;
    assign advance  = item_valid & out_free;

    bgt_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgt_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance_ok (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    bgt_track u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .sum_next  (sum_next),
        .held_next (held_next)
    );

    bgt_decide u_decide
    (
        .cfg     (cfg),
        .sum     (sum_next),
        .held    (held_next),
        .on      (on_next),
        .allowed (allowed_next)
    );

    assign sum_x = bgt_pkg::SUMX_W'(sum_next);

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cooler_on_reg      <= on_next;
            cooler_allowed_reg <= allowed_next;
            battery_sum_reg    <= sum_x[bgt_pkg::BSUM_W-1:0];
            held_temp_reg      <= held_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cooler_on      = cooler_on_reg;
    assign cooler_allowed = cooler_allowed_reg;
    assign battery_sum    = battery_sum_reg;
    assign held_temp      = held_temp_reg;

endmodule

// File: sv/bgt_cfg_regs.sv
module bgt_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bgt_pkg::cfg_t                    cfg
);

    bgt_pkg::cfg_t cfg_reg;
    bgt_pkg::cfg_t cfg_next;

    // Writes are taken in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register write decode; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bgt_pkg::REG_RUN_MODE:
                    cfg_next.run_mode = cfg_data[bgt_pkg::MODE_W-1:0];
                bgt_pkg::REG_SETPOINT:
                    cfg_next.setpoint = cfg_data[bgt_pkg::SET_W-1:0];
                bgt_pkg::REG_ON_OFFSET:
                    cfg_next.on_offset = cfg_data[bgt_pkg::OFS_W-1:0];
                bgt_pkg::REG_CUTOFF:
                    cfg_next.cutoff_counts = cfg_data[bgt_pkg::ADC_W-1:0];
                bgt_pkg::REG_FLOOR:
                    cfg_next.floor_counts = cfg_data[bgt_pkg::ADC_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_mode      <= bgt_pkg::RST_RUN_MODE;
            cfg_reg.setpoint      <= bgt_pkg::RST_SETPOINT;
            cfg_reg.on_offset     <= bgt_pkg::RST_ON_OFFSET;
            cfg_reg.cutoff_counts <= bgt_pkg::RST_CUTOFF;
            cfg_reg.floor_counts  <= bgt_pkg::RST_FLOOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/bgt_in_stage.sv
module bgt_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bgt_pkg::item_t  in_item,
    input  logic            advance_ok,
    output logic            item_valid,
    output bgt_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    bgt_pkg::item_t item_reg;
    logic           load;

    // The stage refills whenever it is empty or its item moves on.
    assign in_stall   = valid_reg & ~advance_ok;
    assign load       = in_valid & ~in_stall;
    assign valid_next = load | (valid_reg & ~advance_ok);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: sv/bgt_track.sv
module bgt_track
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  bgt_pkg::item_t                      item,
    output logic [bgt_pkg::SUM_W-1:0]           sum_next,
    output logic signed [bgt_pkg::TEMP_W-1:0]   held_next
);

    logic [bgt_pkg::ADC_W-1:0]          ring_reg [bgt_pkg::AVG_DEPTH];
    logic [bgt_pkg::PTR_W-1:0]          ptr_reg;
    logic [bgt_pkg::PTR_W-1:0]          ptr_next;
    logic [bgt_pkg::SUM_W-1:0]          sum_reg;
    logic signed [bgt_pkg::TEMP_W-1:0]  held_reg;

    // A valid reading replaces the held temperature.
    assign held_next = item.temp_valid ? item.temp_reading : held_reg;

    // Drop the oldest sample from the sum and add the new one.
    assign sum_next = sum_reg - bgt_pkg::SUM_W'(ring_reg[ptr_reg])
                      + bgt_pkg::SUM_W'(item.adc_sample);

    assign ptr_next = (ptr_reg == bgt_pkg::PTR_W'(bgt_pkg::AVG_DEPTH - 1))
                      ? '0 : ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bgt_pkg::AVG_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            ptr_reg  <= '0;
            sum_reg  <= '0;
            held_reg <= '0;
        end
        else if (advance)
        begin
            ring_reg[ptr_reg] <= item.adc_sample;
            ptr_reg           <= ptr_next;
            sum_reg           <= sum_next;
            held_reg          <= held_next;
        end
    end

endmodule

// File: sv/bgt_decide.sv
module bgt_decide
(
    input  bgt_pkg::cfg_t                       cfg,
    input  logic [bgt_pkg::SUM_W-1:0]           sum,
    input  logic signed [bgt_pkg::TEMP_W-1:0]   held,
    output logic                                on,
    output logic                                allowed
);

    logic [bgt_pkg::SUM_W-1:0]          cut_sum;
    logic [bgt_pkg::SUM_W-1:0]          floor_sum;
    logic                               lockout;
    logic signed [bgt_pkg::LIM_W-1:0]   lim;
    logic signed [bgt_pkg::LIM_W-1:0]   temp_x;

    // Battery thresholds scaled to the ring sum.
    assign cut_sum   = bgt_pkg::SUM_W'(cfg.cutoff_counts)
                       * bgt_pkg::SUM_W'(bgt_pkg::AVG_DEPTH);
    assign floor_sum = bgt_pkg::SUM_W'(cfg.floor_counts)
                       * bgt_pkg::SUM_W'(bgt_pkg::AVG_DEPTH);
    assign lockout   = (sum < cut_sum) && (sum > floor_sum);

    // Thermostat limit at one bit more than the temperature.
    assign lim    = {{(bgt_pkg::LIM_W - bgt_pkg::SET_W){cfg.setpoint[bgt_pkg::SET_W-1]}},
                     cfg.setpoint}
                    + {{(bgt_pkg::LIM_W - bgt_pkg::OFS_W){1'b0}}, cfg.on_offset};
    assign temp_x = {held[bgt_pkg::TEMP_W-1], held};

    // Lockout wins; otherwise the mode decides.
    always_comb
    begin
        allowed = ~lockout;
        on      = 1'b0;
        if (!lockout)
        begin
            unique case (cfg.run_mode)
                bgt_pkg::RUN_FORCED_ON: on = 1'b1;
                bgt_pkg::RUN_AUTOMATIC: on = temp_x > lim;
                default:                on = 1'b0;
            endcase
        end
    end

endmodule
